FILE: design/chd_pkg.sv
// shared types, constants and helpers of the canonical huffman decoder
package chd_pkg;

  localparam int NUM_SYMBOLS_DEF = 288;
  localparam int MAX_LEN_DEF     = 15;
  localparam int WIN_BITS        = 15;
  localparam int FIXED_COUNT     = 288;
  localparam int SYM_W           = 9;
  localparam int LEN_W           = 4;
  localparam int ACT_W           = 3;
  localparam int ST_W            = 2;
  localparam int NUM_LENS        = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 3'd0,
    ACT_LOAD   = 3'd1,
    ACT_BUILD  = 3'd2,
    ACT_FIXED  = 3'd3,
    ACT_DECODE = 3'd4
  } chd_action_t;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOMATCH = 2'd1;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_KRAFT,
    S_CHECK,
    S_DERIVE,
    S_SORT_RD,
    S_SORT_LAT,
    S_SORT_SCAN,
    S_SORT_WR,
    S_FILL,
    S_DEC,
    S_DEC_CAP,
    S_OUT
  } chd_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic kraft_step;
    logic check_fail;
    logic derive_init;
    logic derive_step;
    logic sort_rd;
    logic sort_lat;
    logic sort_scan;
    logic sort_wr;
    logic fill_step;
    logic fin_ok;
    logic dec_look;
    logic dec_cap;
  } chd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic sweep_done;
    logic build_ok;
    logic derive_last;
    logic sort_done;
    logic cur_zero;
    logic fill_last;
  } chd_sts_t;

  // fixed literal/length table in canonical order
  function automatic logic [SYM_W-1:0] fixed_sym(input logic [SYM_W-1:0] i);
    logic [SYM_W-1:0] s;
    if (i < 9'd24)       s = 9'(256 + int'(i));
    else if (i < 9'd168) s = 9'(int'(i) - 24);
    else if (i < 9'd176) s = 9'(280 + int'(i) - 168);
    else                 s = 9'(144 + int'(i) - 176);
    return s;
  endfunction

endpackage

FILE: design/chd_if.sv
// valid/ready channel interfaces for input and result transactions
interface chd_in_if;
  logic                         valid;
  logic                         ready;
  logic [chd_pkg::ACT_W-1:0]    action;
  logic [chd_pkg::SYM_W-1:0]    entry_symbol;
  logic [chd_pkg::LEN_W-1:0]    entry_length;
  logic [chd_pkg::WIN_BITS-1:0] bit_window;
  modport source (output valid, action, entry_symbol, entry_length, bit_window,
                  input ready);
  modport sink (input valid, action, entry_symbol, entry_length, bit_window,
                output ready);
endinterface

interface chd_out_if;
  logic                      valid;
  logic                      ready;
  logic [chd_pkg::SYM_W-1:0] symbol_out;
  logic [chd_pkg::LEN_W-1:0] code_length;
  logic [chd_pkg::ST_W-1:0]  status;
  modport source (output valid, symbol_out, code_length, status, input ready);
  modport sink (input valid, symbol_out, code_length, status, output ready);
endinterface

FILE: design/canonical_huffman_decoder.sv
// top level of the canonical huffman decoder
// Each input transaction carries an action and returns exactly one result transaction.
// Work is done one transaction at a time: in_item.ready is high only while the block is
// idle, and the result then sits on out_item until it is taken. A clear, a load or a
// reserved action goes straight from acceptance to the result. A decode captures the
// window, then compares all fifteen lengths in parallel and reads the sorted symbol
// memory, then captures that read and presents it. Loading the fixed table derives the
// tables one length per cycle and then fills all 288 entries of the symbol memory. A
// build runs the length check over the loaded entries, the derivation and the ordering
// pass, which ranks each used entry by a full sweep of the single-port entry memory.
// The stores hold garbage after reset and need no clearing pass; decodes report no
// match until a table has been built or loaded.
module canonical_huffman_decoder #(
  parameter int NUM_SYMBOLS = chd_pkg::NUM_SYMBOLS_DEF,
  parameter int MAX_LEN     = chd_pkg::MAX_LEN_DEF
) (
  input logic      clk,
  input logic      rst_n,
  chd_in_if.sink   in_item,
  chd_out_if.source out_item
);

  // command and status between controller and datapath
  chd_pkg::chd_cmd_t cmd;
  chd_pkg::chd_sts_t sts;

  chd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_action (in_item.action),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // entry list, canonical tables and symbol memories
  chd_dpath #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .MAX_LEN     (MAX_LEN)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_action (in_item.action),
    .in_symbol (in_item.entry_symbol),
    .in_length (in_item.entry_length),
    .in_window (in_item.bit_window),
    .res_sym   (out_item.symbol_out),
    .res_len   (out_item.code_length),
    .res_st    (out_item.status)
  );

  // a pending result blocks new transactions
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid |-> !in_item.ready)
    else $error("input accepted while a result is pending");

  // a nonzero code length on a valid result only comes with a good status
  a_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && (out_item.code_length != '0)) |-> (out_item.status == chd_pkg::ST_OK))
    else $error("code length reported with a failing status");

  // a miss reports no symbol and no length
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && (out_item.status == chd_pkg::ST_NOMATCH)) |->
      ((out_item.symbol_out == '0) && (out_item.code_length == '0)))
    else $error("miss carries a symbol or length");

  // a result is held until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && !out_item.ready) |=> out_item.valid)
    else $error("result dropped before it was taken");

endmodule

FILE: design/chd_ctrl.sv
// controller state machine of the canonical huffman decoder
module chd_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [chd_pkg::ACT_W-1:0] in_action,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  chd_pkg::chd_sts_t         sts,
  output chd_pkg::chd_cmd_t         cmd
);

  chd_pkg::chd_state_t state_r, state_nxt;
  logic fixed_r, fixed_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chd_pkg::S_IDLE;
      fixed_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fixed_r <= fixed_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fixed_nxt = fixed_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      chd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_action == chd_pkg::ACT_BUILD) begin
            fixed_nxt = 1'b0;
            state_nxt = chd_pkg::S_KRAFT;
          end else if (in_action == chd_pkg::ACT_FIXED) begin
            fixed_nxt       = 1'b1;
            cmd.derive_init = 1'b1;
            state_nxt       = chd_pkg::S_DERIVE;
          end else if (in_action == chd_pkg::ACT_DECODE) begin
            state_nxt = chd_pkg::S_DEC;
          end else begin
            state_nxt = chd_pkg::S_OUT;
          end
        end
      end
      chd_pkg::S_KRAFT: begin
        cmd.kraft_step = 1'b1;
        if (sts.sweep_done) state_nxt = chd_pkg::S_CHECK;
      end
      chd_pkg::S_CHECK: begin
        if (sts.build_ok) begin
          cmd.derive_init = 1'b1;
          state_nxt       = chd_pkg::S_DERIVE;
        end else begin
          cmd.check_fail = 1'b1;
          state_nxt      = chd_pkg::S_OUT;
        end
      end
      chd_pkg::S_DERIVE: begin
        cmd.derive_step = 1'b1;
        if (sts.derive_last) state_nxt = fixed_r ? chd_pkg::S_FILL : chd_pkg::S_SORT_RD;
      end
      chd_pkg::S_SORT_RD: begin
        if (sts.sort_done) begin
          cmd.fin_ok = 1'b1;
          state_nxt  = chd_pkg::S_OUT;
        end else begin
          cmd.sort_rd = 1'b1;
          state_nxt   = chd_pkg::S_SORT_LAT;
        end
      end
      chd_pkg::S_SORT_LAT: begin
        cmd.sort_lat = 1'b1;
        state_nxt    = sts.cur_zero ? chd_pkg::S_SORT_RD : chd_pkg::S_SORT_SCAN;
      end
      chd_pkg::S_SORT_SCAN: begin
        cmd.sort_scan = 1'b1;
        if (sts.sweep_done) state_nxt = chd_pkg::S_SORT_WR;
      end
      chd_pkg::S_SORT_WR: begin
        cmd.sort_wr = 1'b1;
        state_nxt   = chd_pkg::S_SORT_RD;
      end
      chd_pkg::S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) begin
          cmd.fin_ok = 1'b1;
          state_nxt  = chd_pkg::S_OUT;
        end
      end
      chd_pkg::S_DEC: begin
        cmd.dec_look = 1'b1;
        state_nxt    = chd_pkg::S_DEC_CAP;
      end
      chd_pkg::S_DEC_CAP: begin
        cmd.dec_cap = 1'b1;
        state_nxt   = chd_pkg::S_OUT;
      end
      chd_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = chd_pkg::S_IDLE;
      end
      default: state_nxt = chd_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: design/chd_dpath.sv
// datapath: entry list, canonical tables, sorted symbol memory and decode match
module chd_dpath #(
  parameter int NUM_SYMBOLS = chd_pkg::NUM_SYMBOLS_DEF,
  parameter int MAX_LEN     = chd_pkg::MAX_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  chd_pkg::chd_cmd_t            cmd,
  output chd_pkg::chd_sts_t            sts,
  input  logic [chd_pkg::ACT_W-1:0]    in_action,
  input  logic [chd_pkg::SYM_W-1:0]    in_symbol,
  input  logic [chd_pkg::LEN_W-1:0]    in_length,
  input  logic [chd_pkg::WIN_BITS-1:0] in_window,
  output logic [chd_pkg::SYM_W-1:0]    res_sym,
  output logic [chd_pkg::LEN_W-1:0]    res_len,
  output logic [chd_pkg::ST_W-1:0]     res_st
);

  localparam int SW     = chd_pkg::SYM_W;
  localparam int LW     = chd_pkg::LEN_W;
  localparam int WB     = chd_pkg::WIN_BITS;
  localparam int NL     = chd_pkg::NUM_LENS;
  localparam int AW     = $clog2(NUM_SYMBOLS);
  localparam int CW     = $clog2(NUM_SYMBOLS + 1);
  localparam int SDEPTH = (NUM_SYMBOLS > chd_pkg::FIXED_COUNT) ? NUM_SYMBOLS
                                                               : chd_pkg::FIXED_COUNT;
  localparam int SAW    = $clog2(SDEPTH);
  localparam int PW     = $clog2(512 + NUM_SYMBOLS);
  localparam int IW     = SW + 1;
  localparam int KW     = MAX_LEN + CW;
  localparam logic [KW-1:0] KRAFT_ONE = KW'(1) << MAX_LEN;

  // entry list memory
  logic [SW+LW-1:0] ent_mem [NUM_SYMBOLS];
  logic [SW+LW-1:0] ent_rd_r;
  logic [CW-1:0]    ent_cnt_r;
  logic             ent_we, ent_re;
  logic [AW-1:0]    ent_ra;

  // sorted symbol memory
  logic [SW-1:0]  sort_mem [SDEPTH];
  logic [SW-1:0]  sort_rd_r;
  logic           sort_we, sort_re;
  logic [SAW-1:0] sort_wa, sort_ra;
  logic [SW-1:0]  sort_wd;

  // canonical tables
  logic [SW-1:0] cnt_len_r [NL];
  logic [15:0]   fcode_r   [NL];
  logic [SW-1:0] fidx_r    [NL];
  logic [LW-1:0] lo_r, hi_r;
  logic          tvalid_r;

  // sweep over the entry list through the registered memory read
  logic [CW-1:0] swp_cnt_r, swp_j_r;
  logic          swp_vld_r, swp_issue, swp_on;

  logic [KW-1:0] kraft_r;
  logic          used_r, bad_r;

  logic [LW-1:0] dk_r;
  logic [15:0]   dcode_r, dcode_nxt;
  logic [SW-1:0] didx_r, didx_nxt, dprev_r;

  logic [CW-1:0]  si_r;
  logic [SW-1:0]  cur_sym_r;
  logic [LW-1:0]  cur_len_r;
  logic [PW-1:0]  pos_r;
  logic [SAW-1:0] fcnt_r;

  logic [WB-1:0] win_r;
  logic          dhit_r;
  logic [LW-1:0] dlen_r;

  logic [SW-1:0] res_sym_r;
  logic [LW-1:0] res_len_r;
  logic [1:0]    res_st_r;

  logic [LW-1:0] rd_len;
  logic [SW-1:0] rd_sym;
  logic [KW-1:0] kraft_inc;

  // decode match
  logic [NL-1:0] m;
  logic [SW-1:0] off [NL];
  logic [LW-1:0] sel;
  logic          any;
  logic [IW-1:0] didx;

  assign rd_len    = ent_rd_r[LW-1:0];
  assign rd_sym    = ent_rd_r[SW+LW-1:LW];
  assign kraft_inc = KW'(1) << (LW'(MAX_LEN) - rd_len);

  assign swp_on    = cmd.kraft_step | cmd.sort_scan;
  assign swp_issue = swp_on && (swp_cnt_r < ent_cnt_r);

  assign ent_we = cmd.accept && (in_action == chd_pkg::ACT_LOAD) &&
                  (ent_cnt_r < CW'(NUM_SYMBOLS));
  assign ent_re = swp_issue | cmd.sort_rd;
  assign ent_ra = cmd.sort_rd ? si_r[AW-1:0] : swp_cnt_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_cnt_r[AW-1:0]] <= {in_symbol, in_length};
    if (ent_re) ent_rd_r <= ent_mem[ent_ra];
  end

  assign sort_we = (cmd.sort_wr && (pos_r < PW'(SDEPTH))) || cmd.fill_step;
  assign sort_wa = cmd.fill_step ? fcnt_r : pos_r[SAW-1:0];
  assign sort_wd = cmd.fill_step ? chd_pkg::fixed_sym(SW'(fcnt_r)) : cur_sym_r;
  assign sort_re = cmd.dec_look && any && (didx < IW'(SDEPTH));
  assign sort_ra = didx[SAW-1:0];

  always_ff @(posedge clk) begin
    if (sort_we) sort_mem[sort_wa] <= sort_wd;
    if (sort_re) sort_rd_r <= sort_mem[sort_ra];
  end

  // one length per cycle of first code and first index
  assign dcode_nxt = 16'((dcode_r + 16'(dprev_r)) << 1);
  assign didx_nxt  = SW'(didx_r + dprev_r);

  always_comb begin
    logic [16:0] diff;
    logic [WB-1:0] code;
    m   = '0;
    sel = '0;
    any = 1'b0;
    for (int l = 0; l < NL; l++) begin
      off[l] = '0;
    end
    for (int l = 1; l < NL; l++) begin
      code   = WB'(win_r >> (WB - l));
      diff   = {2'b00, code} - {1'b0, fcode_r[l]};
      off[l] = diff[SW-1:0];
      m[l]   = (LW'(l) >= lo_r) && (LW'(l) <= hi_r) && !diff[16] &&
               (diff[15:0] < {7'b0, cnt_len_r[l]});
    end
    for (int l = NL - 1; l >= 1; l--) begin
      if (m[l]) begin
        sel = LW'(l);
        any = 1'b1;
      end
    end
    didx = {1'b0, fidx_r[sel]} + {1'b0, off[sel]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_cnt_r <= '0;
      tvalid_r  <= 1'b0;
      lo_r      <= '0;
      hi_r      <= '0;
      swp_vld_r <= 1'b0;
      for (int l = 0; l < NL; l++) begin
        cnt_len_r[l] <= '0;
        fcode_r[l]   <= '0;
        fidx_r[l]    <= '0;
      end
    end else begin
      if (cmd.accept) begin
        res_sym_r <= '0;
        res_len_r <= '0;
        res_st_r  <= chd_pkg::ST_OK;
        win_r     <= in_window;
        if (in_action == chd_pkg::ACT_CLEAR) ent_cnt_r <= '0;
        if (ent_we) ent_cnt_r <= ent_cnt_r + CW'(1);
        if (in_action == chd_pkg::ACT_BUILD) begin
          tvalid_r  <= 1'b0;
          kraft_r   <= '0;
          used_r    <= 1'b0;
          bad_r     <= 1'b0;
          swp_cnt_r <= '0;
          swp_vld_r <= 1'b0;
          for (int l = 0; l < NL; l++) cnt_len_r[l] <= '0;
        end
        if (in_action == chd_pkg::ACT_FIXED) begin
          fcnt_r <= '0;
          // fixed literal/length histogram: 24 of length 7, 152 of 8, 112 of 9
          for (int l = 0; l < NL; l++) begin
            cnt_len_r[l] <= (l == 7) ? SW'(24) :
                            (l == 8) ? SW'(152) :
                            (l == 9) ? SW'(112) : SW'(0);
          end
        end
      end

      if (swp_on) begin
        swp_vld_r <= swp_issue;
        swp_j_r   <= swp_cnt_r;
        if (swp_issue) swp_cnt_r <= swp_cnt_r + CW'(1);
      end

      // length check and histogram
      if (cmd.kraft_step && swp_vld_r && (rd_len != '0)) begin
        used_r <= 1'b1;
        if (rd_len > LW'(MAX_LEN)) begin
          bad_r <= 1'b1;
        end else begin
          kraft_r           <= kraft_r + kraft_inc;
          cnt_len_r[rd_len] <= cnt_len_r[rd_len] + SW'(1);
        end
      end

      if (cmd.check_fail) res_st_r <= chd_pkg::ST_INVALID;

      if (cmd.derive_init) begin
        dk_r       <= LW'(1);
        dcode_r    <= '0;
        didx_r     <= '0;
        dprev_r    <= '0;
        lo_r       <= '0;
        hi_r       <= '0;
        si_r       <= '0;
        fcode_r[0] <= '0;
        fidx_r[0]  <= '0;
      end

      if (cmd.derive_step) begin
        fcode_r[dk_r] <= dcode_nxt;
        fidx_r[dk_r]  <= didx_nxt;
        dcode_r       <= dcode_nxt;
        didx_r        <= didx_nxt;
        dprev_r       <= cnt_len_r[dk_r];
        if ((cnt_len_r[dk_r] != '0) && (dk_r <= LW'(MAX_LEN))) begin
          if (lo_r == '0) lo_r <= dk_r;
          hi_r <= dk_r;
        end
        dk_r <= dk_r + LW'(1);
      end

      if (cmd.sort_lat) begin
        cur_sym_r <= rd_sym;
        cur_len_r <= rd_len;
        pos_r     <= PW'(fidx_r[rd_len]);
        swp_cnt_r <= '0;
        swp_vld_r <= 1'b0;
        if (rd_len == '0) si_r <= si_r + CW'(1);
      end

      // rank among entries of the same length
      if (cmd.sort_scan && swp_vld_r && (rd_len == cur_len_r) &&
          ((rd_sym < cur_sym_r) || ((rd_sym == cur_sym_r) && (swp_j_r < si_r)))) begin
        pos_r <= pos_r + PW'(1);
      end

      if (cmd.sort_wr) si_r <= si_r + CW'(1);
      if (cmd.fill_step) fcnt_r <= fcnt_r + SAW'(1);
      if (cmd.fin_ok) tvalid_r <= 1'b1;

      if (cmd.dec_look) begin
        dhit_r <= tvalid_r && any && (didx < IW'(SDEPTH));
        dlen_r <= sel;
      end

      if (cmd.dec_cap) begin
        if (dhit_r) begin
          res_sym_r <= sort_rd_r;
          res_len_r <= dlen_r;
          res_st_r  <= chd_pkg::ST_OK;
        end else begin
          res_sym_r <= '0;
          res_len_r <= '0;
          res_st_r  <= chd_pkg::ST_NOMATCH;
        end
      end
    end
  end

  assign sts.sweep_done  = (swp_cnt_r == ent_cnt_r) && !swp_vld_r;
  assign sts.build_ok    = !bad_r && used_r && (kraft_r <= KRAFT_ONE);
  assign sts.derive_last = (dk_r == LW'(NL - 1));
  assign sts.sort_done   = (si_r == ent_cnt_r);
  assign sts.cur_zero    = (rd_len == '0);
  assign sts.fill_last   = (fcnt_r == SAW'(chd_pkg::FIXED_COUNT - 1));

  assign res_sym = res_sym_r;
  assign res_len = res_len_r;
  assign res_st  = res_st_r;

endmodule

FILE: bench/canonical_huffman_decoder_test.sv
// testbench of the canonical huffman decoder: directed and random transactions, scoreboard check
`timescale 1ns / 1ps

module canonical_huffman_decoder_test;

  // actions the block does not define, expected to change nothing
  localparam logic [chd_pkg::ACT_W-1:0] ACT_RSVD_5 = 3'd5;
  localparam logic [chd_pkg::ACT_W-1:0] ACT_RSVD_6 = 3'd6;
  localparam logic [chd_pkg::ACT_W-1:0] ACT_RSVD_7 = 3'd7;
  localparam int LIST_DEPTH  = 288;
  localparam int STALL_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 850;

  typedef struct packed {
    logic [chd_pkg::SYM_W-1:0] symbol;
    logic [chd_pkg::LEN_W-1:0] length;
    logic [chd_pkg::ST_W-1:0]  status;
  } decode_result_t;

  // predicts each result from the accepted transactions and checks the block against it
  class huffman_scoreboard;
    logic [chd_pkg::SYM_W-1:0] entry_sym[LIST_DEPTH];
    logic [chd_pkg::LEN_W-1:0] entry_len[LIST_DEPTH];
    int                        entries;
    int                        per_len[chd_pkg::NUM_LENS];
    logic [15:0]               base_code[chd_pkg::NUM_LENS];
    logic [chd_pkg::SYM_W-1:0] base_index[chd_pkg::NUM_LENS];
    logic [chd_pkg::SYM_W-1:0] canon_sym[LIST_DEPTH];
    int                        shortest, longest;
    bit                        have_table;
    decode_result_t            pending[$];
    int                        errors;

    function new();
      entries = 0;
      shortest = 0;
      longest = 0;
      have_table = 0;
      errors = 0;
      foreach (per_len[i]) begin
        per_len[i] = 0;
        base_code[i] = '0;
        base_index[i] = '0;
      end
    endfunction

    // canonical first code and first index per length
    function void derive_bases();
      logic [15:0]               code;
      logic [chd_pkg::SYM_W-1:0] idx;
      int                        prev;
      code = '0;
      idx = '0;
      base_code[0] = '0;
      base_index[0] = '0;
      for (int l = 1; l < chd_pkg::NUM_LENS; l++) begin
        prev = (l == 1) ? 0 : per_len[l-1];
        code = 16'((code + prev) << 1);
        idx = chd_pkg::SYM_W'(idx + prev);
        base_code[l] = code;
        base_index[l] = idx;
      end
    endfunction

    function logic [chd_pkg::ST_W-1:0] build_codes();
      int kraft, used, pos;
      kraft = 0;
      used = 0;
      have_table = 0;
      for (int i = 0; i < entries; i++) begin
        if (entry_len[i] == 0) continue;
        kraft += 1 << (chd_pkg::MAX_LEN_DEF - entry_len[i]);
        used++;
      end
      if (used == 0 || kraft > (1 << chd_pkg::MAX_LEN_DEF)) return chd_pkg::ST_INVALID;
      foreach (per_len[l]) per_len[l] = 0;
      for (int i = 0; i < entries; i++)
        if (entry_len[i] != 0) per_len[entry_len[i]]++;
      derive_bases();
      shortest = 0;
      longest = 0;
      for (int l = 1; l <= chd_pkg::MAX_LEN_DEF; l++) begin
        if (per_len[l] != 0) begin
          if (shortest == 0) shortest = l;
          longest = l;
        end
      end
      // rank by length, then symbol, then load order
      for (int i = 0; i < entries; i++) begin
        if (entry_len[i] == 0) continue;
        pos = base_index[entry_len[i]];
        for (int j = 0; j < entries; j++) begin
          if (entry_len[j] != entry_len[i]) continue;
          if (entry_sym[j] < entry_sym[i] || (entry_sym[j] == entry_sym[i] && j < i)) pos++;
        end
        if (pos < LIST_DEPTH) canon_sym[pos] = entry_sym[i];
      end
      have_table = 1;
      return chd_pkg::ST_OK;
    endfunction

    function void load_fixed_codes();
      foreach (per_len[l]) per_len[l] = 0;
      per_len[7] = 24;
      per_len[8] = 152;
      per_len[9] = 112;
      derive_bases();
      for (int i = 0; i < 24; i++) canon_sym[i] = chd_pkg::SYM_W'(256 + i);
      for (int i = 0; i < 144; i++) canon_sym[24 + i] = chd_pkg::SYM_W'(i);
      for (int i = 0; i < 8; i++) canon_sym[168 + i] = chd_pkg::SYM_W'(280 + i);
      for (int i = 0; i < 112; i++) canon_sym[176 + i] = chd_pkg::SYM_W'(144 + i);
      shortest = 7;
      longest = 9;
      have_table = 1;
    endfunction

    function decode_result_t decode_window(logic [chd_pkg::WIN_BITS-1:0] win);
      decode_result_t r;
      int code, idx;
      r = '{symbol: '0, length: '0, status: chd_pkg::ST_NOMATCH};
      if (!have_table) return r;
      for (int l = shortest; l != 0 && l <= longest && l <= chd_pkg::WIN_BITS; l++) begin
        code = int'(win >> (chd_pkg::WIN_BITS - l));
        if (code >= base_code[l] && code - base_code[l] < per_len[l]) begin
          idx = base_index[l] + (code - base_code[l]);
          if (idx < LIST_DEPTH) begin
            r.symbol = canon_sym[idx];
            r.length = chd_pkg::LEN_W'(l);
            r.status = chd_pkg::ST_OK;
          end
          break;
        end
      end
      return r;
    endfunction

    function void note_input(logic [chd_pkg::ACT_W-1:0] act, logic [chd_pkg::SYM_W-1:0] sym,
                             logic [chd_pkg::LEN_W-1:0] len,
                             logic [chd_pkg::WIN_BITS-1:0] win);
      decode_result_t r;
      r = '0;
      unique case (act)
        chd_pkg::ACT_CLEAR: entries = 0;
        chd_pkg::ACT_LOAD: begin
          // a full list drops the load
          if (entries < LIST_DEPTH) begin
            entry_sym[entries] = sym;
            entry_len[entries] = len;
            entries++;
          end
        end
        chd_pkg::ACT_BUILD:  r.status = build_codes();
        chd_pkg::ACT_FIXED:  load_fixed_codes();
        chd_pkg::ACT_DECODE: r = decode_window(win);
        default: ;
      endcase
      pending = {pending, r};
    endfunction

    function void check_result(decode_result_t got);
      decode_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result sym %0d len %0d st %0d", $time,
                 got.symbol, got.length, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.symbol !== want.symbol) begin
        $display("%0t: symbol_out expected %0d actual %0d", $time, want.symbol, got.symbol);
        errors++;
      end
      if (got.length !== want.length) begin
        $display("%0t: code_length expected %0d actual %0d", $time, want.length, got.length);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  chd_in_if  in_ch();
  chd_out_if out_ch();

  canonical_huffman_decoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  huffman_scoreboard sb = new();
  int in_idle_pct;   // chance in percent that the sender holds off
  int out_idle_pct;  // chance in percent that the receiver stalls
  int sent;
  int quiet_cycles = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // sample both channels at the edge, before any driven update lands
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_input(in_ch.action, in_ch.entry_symbol, in_ch.entry_length, in_ch.bit_window);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{symbol: out_ch.symbol_out, length: out_ch.code_length,
                         status: out_ch.status});
  end

  // receiver stalls at random
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("canonical_huffman_decoder_test NOT OK");
      $finish;
    end
  end

  // idling schedule: receiver-heavy stalls, then sender-heavy gaps, then none
  function void set_idling();
    if (sent < 350) begin
      in_idle_pct = 33;
      out_idle_pct = 88;
    end else if (sent < 700) begin
      in_idle_pct = 88;
      out_idle_pct = 33;
    end else begin
      in_idle_pct = 0;
      out_idle_pct = 0;
    end
  endfunction

  // one input transaction; valid stays high when the next one follows without a gap
  task automatic send(logic [chd_pkg::ACT_W-1:0] act, logic [chd_pkg::SYM_W-1:0] sym = '0,
                      logic [chd_pkg::LEN_W-1:0] len = '0,
                      logic [chd_pkg::WIN_BITS-1:0] win = '0);
    bit lowered;
    lowered = 0;
    set_idling();
    while ($urandom_range(99) < in_idle_pct) begin
      if (!lowered) in_ch.valid <= 1'b0;
      lowered = 1;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.entry_symbol <= sym;
    in_ch.entry_length <= len;
    in_ch.bit_window   <= win;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic send_random_window();
    send(chd_pkg::ACT_DECODE, chd_pkg::SYM_W'($urandom), chd_pkg::LEN_W'($urandom),
         chd_pkg::WIN_BITS'($urandom));
  endtask

  // clear, load a small list (mostly satisfying the kraft sum), build, decode a burst
  task automatic code_set_sequence();
    int k, kraft;
    logic [chd_pkg::LEN_W-1:0] lens[16];
    k = $urandom_range(1, 12);
    kraft = 0;
    for (int i = 0; i < k; i++) begin
      case ($urandom_range(9))
        0:       lens[i] = '0;
        1:       lens[i] = chd_pkg::LEN_W'($urandom_range(1, 15));
        default: lens[i] = chd_pkg::LEN_W'($urandom_range(1, 5));
      endcase
      if (lens[i] != 0) kraft += 1 << (15 - lens[i]);
    end
    // usually push lengths up until the set fits
    if ($urandom_range(9) != 0) begin
      for (int i = 0; i < k && kraft > 32768; i++) begin
        while (lens[i] != 0 && lens[i] < 15 && kraft > 32768) begin
          kraft -= 1 << (15 - lens[i]);
          lens[i]++;
          kraft += 1 << (15 - lens[i]);
        end
      end
    end
    send(chd_pkg::ACT_CLEAR);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(15) == 0)
        send(chd_pkg::ACT_LOAD, chd_pkg::SYM_W'($urandom_range(288, 511)), lens[i]);
      else
        send(chd_pkg::ACT_LOAD, chd_pkg::SYM_W'($urandom_range(0, 287)), lens[i]);
    end
    send(chd_pkg::ACT_BUILD);
    repeat ($urandom_range(4, 16)) send_random_window();
  endtask

  // fills the list past its depth, then builds the largest set once
  task automatic full_list_sequence();
    send(chd_pkg::ACT_CLEAR);
    for (int i = 0; i < LIST_DEPTH + 1; i++)
      send(chd_pkg::ACT_LOAD, chd_pkg::SYM_W'(LIST_DEPTH - 1 - i),
           (i < 256) ? 4'd8 : 4'd0);
    send(chd_pkg::ACT_BUILD);
    repeat (8) send_random_window();
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = chd_pkg::ACT_CLEAR;
    in_ch.entry_symbol = '0;
    in_ch.entry_length = '0;
    in_ch.bit_window = '0;
    sent = 0;
    set_idling();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: no table yet, reserved actions, empty build
    send(chd_pkg::ACT_DECODE, '0, '0, 15'h7fff);
    send(ACT_RSVD_5, 9'h1ff, 4'hf, 15'h7fff);
    send(ACT_RSVD_6);
    send(ACT_RSVD_7);
    send(chd_pkg::ACT_BUILD);
    send(chd_pkg::ACT_LOAD, 9'd3, 4'd0);
    send(chd_pkg::ACT_BUILD);
    // fixed table at both ends of the window
    send(chd_pkg::ACT_FIXED);
    send(chd_pkg::ACT_DECODE, '0, '0, 15'h0000);
    send(chd_pkg::ACT_DECODE, '0, '0, 15'h7fff);
    send(chd_pkg::ACT_DECODE, '0, '0, 15'h6000);
    // two one-bit codes, one symbol beyond the literal range
    send(chd_pkg::ACT_CLEAR);
    send(chd_pkg::ACT_LOAD, 9'h1ff, 4'd1);
    send(chd_pkg::ACT_LOAD, 9'd0, 4'd1);
    send(chd_pkg::ACT_BUILD);
    send(chd_pkg::ACT_DECODE, '0, '0, 15'h0000);
    send(chd_pkg::ACT_DECODE, '0, '0, 15'h7fff);
    // kraft sum above one fails and drops the table
    send(chd_pkg::ACT_LOAD, 9'd7, 4'd1);
    send(chd_pkg::ACT_BUILD);
    send(chd_pkg::ACT_DECODE, '0, '0, 15'h1234);
    // lone longest code, incomplete set
    send(chd_pkg::ACT_CLEAR);
    send(chd_pkg::ACT_LOAD, 9'd287, 4'd15);
    send(chd_pkg::ACT_BUILD);
    send(chd_pkg::ACT_DECODE, '0, '0, 15'h0000);
    send(chd_pkg::ACT_DECODE, '0, '0, 15'h0001);

    full_list_sequence();
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(19))
        0: begin
          send(chd_pkg::ACT_FIXED);
          repeat ($urandom_range(4, 12)) send_random_window();
        end
        1: send(logic'($urandom_range(1)) ? ACT_RSVD_5 : ACT_RSVD_7,
                chd_pkg::SYM_W'($urandom), chd_pkg::LEN_W'($urandom),
                chd_pkg::WIN_BITS'($urandom));
        2: send(chd_pkg::ACT_LOAD, chd_pkg::SYM_W'($urandom), chd_pkg::LEN_W'($urandom));
        3: send_random_window();
        4: send(chd_pkg::ACT_BUILD);
        default: code_set_sequence();
      endcase
    end
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("canonical_huffman_decoder_test OK");
    else $display("canonical_huffman_decoder_test NOT OK");
    $finish;
  end

endmodule
